>>> rtl/ndm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndm_pkg
// Shared types and character constants of the nested delimiter matcher.
// ----------------------------------------------------------------------------
package ndm_pkg;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_BAD_ESCAPE = 2'd2;
    localparam logic [1:0] ST_LIMIT      = 2'd3;

    localparam int OFFSET_W = 16;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_BSLASH,
        ESC_CR
    } esc_t;

    // classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] wanted;
        logic       first;
        logic       last;
        logic       is_bslash;
        logic       is_cr;
        logic       follow_ok;
        logic       opens;
        logic [7:0] push_closer;
    } ndm_item_t;

endpackage
`default_nettype wire

>>> rtl/ndm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndm_front
// Classifies each incoming byte: escape followers, openers and their closers.
// ----------------------------------------------------------------------------
module ndm_front
    import ndm_pkg::*;
(
    input  wire logic [7:0] char_in,
    input  wire logic       first,
    input  wire logic       last,
    input  wire logic [7:0] wanted_closer,
    output ndm_item_t       item
);

    logic is_quote;

    always_comb begin
        is_quote         = (char_in == CH_DQUOTE) || (char_in == CH_SQUOTE);
        item.ch          = char_in;
        item.wanted      = wanted_closer;
        item.first       = first;
        item.last        = last;
        item.is_bslash   = (char_in == CH_BSLASH);
        item.is_cr       = (char_in == CH_CR);
        item.follow_ok   = (char_in == CH_LF) || (char_in == CH_BSLASH) ||
                           (char_in == CH_LOW_N) || (char_in == CH_LOW_R) ||
                           (char_in == CH_LOW_T) || is_quote;
        item.opens       = 1'b1;
        item.push_closer = char_in;
        unique case (char_in) inside
            CH_LBRACE: item.push_closer = CH_RBRACE;
            CH_LPAREN: item.push_closer = CH_RPAREN;
            CH_LBRACK: item.push_closer = CH_RBRACK;
            CH_DQUOTE, CH_SQUOTE: item.push_closer = char_in;
            default: item.opens = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/ndm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndm_queue
// Two-entry queue between the classifier and the scan engine.
// ----------------------------------------------------------------------------
module ndm_queue
    import ndm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  ndm_item_t      in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output ndm_item_t      out_item
);

    ndm_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    always_comb begin
        in_ready    = (count_reg != 2'd2);
        out_valid   = (count_reg != 2'd0);
        out_item    = entry_reg[rd_ptr_reg];
        push        = in_valid && in_ready;
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ndm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndm_back
// Scan engine: closer stack, escape tracking, offset count and result register.
// ----------------------------------------------------------------------------
module ndm_back
    import ndm_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int LVL_W       = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  ndm_item_t                in_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic [OFFSET_W-1:0]      m_position,
    output logic                     scan_active,
    output logic [LVL_W-1:0]         nest_level
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);
    localparam logic [LVL_W-1:0] LVL_TWO = LVL_W'(2);
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(STACK_DEPTH);

    // entries below the top; the top closer lives in top_reg
    logic [7:0] stack_mem [STACK_DEPTH];
    logic [7:0] below_reg;

    logic              active_reg, active_next;
    esc_t              esc_reg, esc_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [7:0]        top_reg, top_next;
    logic [OFFSET_W:0] off_reg, off_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [OFFSET_W-1:0] pos_reg, pos_next;

    logic              take, emit;
    logic [LVL_W-1:0]  eff_level;
    logic [7:0]        eff_top;
    esc_t              eff_esc;
    logic [OFFSET_W:0] eff_off;
    logic              top_is_quote;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [LVL_W-1:0]  rd_level;

    always_comb begin
        take         = in_valid && (!m_valid_reg || m_ready);
        in_ready     = !m_valid_reg || m_ready;
        eff_level    = in_item.first ? LVL_ONE : level_reg;
        eff_top      = in_item.first ? in_item.wanted : top_reg;
        eff_esc      = in_item.first ? ESC_NONE : esc_reg;
        if (in_item.first) begin
            eff_off = '0;
        end else if (off_reg[OFFSET_W]) begin
            eff_off = off_reg;
        end else begin
            eff_off = off_reg + 1'b1;
        end
        top_is_quote = (eff_top == CH_DQUOTE) || (eff_top == CH_SQUOTE);

        active_next  = active_reg;
        esc_next     = esc_reg;
        level_next   = level_reg;
        top_next     = top_reg;
        off_next     = off_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        emit         = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = IDX_W'(eff_level - LVL_ONE);

        if (take && (in_item.first || active_reg)) begin
            active_next = 1'b1;
            level_next  = eff_level;
            top_next    = eff_top;
            esc_next    = eff_esc;
            off_next    = eff_off;
            pos_next    = '0;
            if (eff_off[OFFSET_W]) begin
                emit        = 1'b1;
                status_next = ST_LIMIT;
            end else begin
                unique case (eff_esc)
                    ESC_BSLASH: begin
                        if (in_item.is_cr) begin
                            esc_next = ESC_CR;
                        end else if (in_item.follow_ok) begin
                            esc_next = ESC_NONE;
                        end else begin
                            emit        = 1'b1;
                            status_next = ST_BAD_ESCAPE;
                        end
                    end
                    ESC_CR: begin
                        if (in_item.ch == CH_LF) begin
                            esc_next = ESC_NONE;
                        end else begin
                            emit        = 1'b1;
                            status_next = ST_BAD_ESCAPE;
                        end
                    end
                    default: begin
                        if (in_item.ch == eff_top) begin
                            if (eff_level == LVL_ONE) begin
                                emit        = 1'b1;
                                status_next = ST_FOUND;
                                pos_next    = eff_off[OFFSET_W-1:0];
                            end else begin
                                level_next = eff_level - LVL_ONE;
                                top_next   = below_reg;
                            end
                        end else if (in_item.is_bslash) begin
                            esc_next = ESC_BSLASH;
                        end else if (!top_is_quote && in_item.opens) begin
                            if (eff_level >= LVL_MAX) begin
                                emit        = 1'b1;
                                status_next = ST_LIMIT;
                            end else begin
                                // spill the old top below the new one
                                wr_en      = 1'b1;
                                top_next   = in_item.push_closer;
                                level_next = eff_level + LVL_ONE;
                            end
                        end
                    end
                endcase
            end
            if (!emit && in_item.last) begin
                emit        = 1'b1;
                status_next = (esc_next != ESC_NONE) ? ST_BAD_ESCAPE : ST_NOT_FOUND;
            end
            if (emit) begin
                active_next = 1'b0;
                esc_next    = ESC_NONE;
            end
        end

        if (take && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        // prefetch the entry under the next top
        rd_level = level_next - LVL_TWO;
        rd_addr  = rd_level[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= eff_top;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            below_reg <= eff_top;
        end else begin
            below_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            esc_reg     <= ESC_NONE;
            level_reg   <= '0;
            off_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            esc_reg     <= esc_next;
            level_reg   <= level_next;
            off_reg     <= off_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_position  = pos_reg;
    assign scan_active = active_reg;
    assign nest_level  = level_reg;

endmodule
`default_nettype wire

>>> rtl/nested_delimiter_matcher_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nested_delimiter_matcher_core
// Streaming balanced delimiter matcher: finds the top-level closer of a byte
// range, honoring nested brackets, quote scopes and backslash escapes.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                               | flow
//  s_       | in        | char_in, first, last, wanted_closer   | valid/ready
//  m_       | out       | status, position                      | valid/ready
//
//  one byte per cycle sustained while the result side does not stall; the scan
//  engine handles each byte with the top closer held in a register and the entry
//  beneath it prefetched from the stack memory.
//  a byte's result passes through the queue entry and then the result register;
//  bytes left waiting in the queue by a stall delay it further.
//  synchronous active-low reset clears the queue, scan state and result valid.
//  a stalled result holds the engine; the two-entry queue keeps s_ready high
//  until two bytes are waiting.
// ----------------------------------------------------------------------------
module nested_delimiter_matcher_core
    import ndm_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_char_in,
    input  wire logic                 s_first,
    input  wire logic                 s_last,
    input  wire logic [7:0]           s_wanted_closer,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_status,
    output logic [OFFSET_W-1:0]       m_position
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    ndm_item_t        front_item;
    ndm_item_t        q_item;
    logic             q_valid;
    logic             q_ready;
    logic             scan_active;
    logic [LVL_W-1:0] nest_level;

    ndm_front u_front (
        .char_in       (s_char_in),
        .first         (s_first),
        .last          (s_last),
        .wanted_closer (s_wanted_closer),
        .item          (front_item)
    );

    ndm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    ndm_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .LVL_W       (LVL_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_item     (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_position  (m_position),
        .scan_active (scan_active),
        .nest_level  (nest_level)
    );

    // a running scan always has the top-level closer on the stack
    a_level_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_active |-> (nest_level != '0) && (nest_level <= LVL_W'(STACK_DEPTH)))
        else $error("nest level out of range during a scan");

    // offset is reported only for a match
    a_position_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_FOUND)) |-> (m_position == '0))
        else $error("nonzero position on a failure result");

    // no result and no running scan right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !scan_active)
        else $error("state not cleared by reset");

endmodule
`default_nettype wire
